// ===== design/masc_pkg.sv =====
// Shared types, constants and a helper function of the movie atom carver.
package masc_pkg;

   localparam int BLOCK_W       = 25;
   localparam int NUMBER_W      = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BLOCK_W-1:0]  BLOCK_SIZE_RESET   = BLOCK_W'(512);
   localparam logic [NUMBER_W-1:0] FIRST_NUMBER_RESET = '0;

   // Register indexes as decoded from the address (byte address 4 * index).
   localparam logic REG_BLOCK_SIZE   = 1'b0;
   localparam logic REG_FIRST_NUMBER = 1'b1;

   // Atom type codes, four ASCII characters read big-endian.
   localparam logic [31:0] TYPE_FTYP = 32'h6674_7970;
   localparam logic [31:0] TYPE_MOOV = 32'h6D6F_6F76;
   localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;
   localparam logic [31:0] TYPE_FREE = 32'h6672_6565;
   localparam logic [31:0] TYPE_SKIP = 32'h736B_6970;
   localparam logic [31:0] TYPE_WIDE = 32'h7769_6465;
   localparam logic [31:0] TYPE_PNOT = 32'h706E_6F74;

   typedef enum logic [1:0] {
      PH_SCAN   = 2'd0,
      PH_HEADER = 2'd1,
      PH_COPY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  block_size;
      logic                number_load;
      logic [NUMBER_W-1:0] number_value;
   } cfg_type;

   // One queue entry: either a single result or a burst of eight header bytes.
   typedef struct packed {
      logic [63:0]         bytes;
      logic                burst;
      logic                present;
      logic                start;
      logic                fin;
      logic [NUMBER_W-1:0] number;
   } desc_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                byte_present;
      logic [NUMBER_W-1:0] file_number;
      logic                file_start;
      logic                file_end;
      logic                run_last;
   } res_type;

   function automatic logic type_ok(input logic [31:0] code);
      type_ok = (code == TYPE_FTYP) || (code == TYPE_MOOV) || (code == TYPE_MDAT) ||
                (code == TYPE_FREE) || (code == TYPE_SKIP) || (code == TYPE_WIDE) ||
                (code == TYPE_PNOT);
   endfunction

endpackage

// ===== design/masc_csr.sv =====
// Configuration registers of the movie atom carver behind a simple APB-style port.
module masc_csr
   import masc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output cfg_type             cfg
);

   logic [BLOCK_W-1:0]  block_size_ff;
   logic [BLOCK_W-1:0]  block_size_in;
   logic [NUMBER_W-1:0] first_number_ff;
   logic [NUMBER_W-1:0] first_number_in;
   logic                write_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      block_size_in   = block_size_ff;
      first_number_in = first_number_ff;
      if (write_en) begin
         case (reg_sel)
            REG_BLOCK_SIZE:   block_size_in   = csr_pwdata[BLOCK_W-1:0];
            REG_FIRST_NUMBER: first_number_in = csr_pwdata;
            default:          block_size_in   = block_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= BLOCK_SIZE_RESET;
         first_number_ff <= FIRST_NUMBER_RESET;
      end else begin
         block_size_ff   <= block_size_in;
         first_number_ff <= first_number_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BLOCK_SIZE:   csr_prdata = 32'(block_size_ff);
         REG_FIRST_NUMBER: csr_prdata = first_number_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // A write of the first number also reloads the running file number.
   assign cfg.block_size   = block_size_ff;
   assign cfg.number_load  = write_en & (reg_sel == REG_FIRST_NUMBER);
   assign cfg.number_value = csr_pwdata;

endmodule

// ===== design/masc_parse.sv =====
// Input register and single-pass scan and atom header parser of the carver.
module masc_parse
   import masc_pkg::*;
#(
   parameter int OFFSET_BITS = 24
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_load,
   input  logic [7:0] in_byte,
   input  logic     in_eos,
   output logic     busy,
   output logic     push,
   output desc_type push_desc
);

   localparam int EW = (OFFSET_BITS + 1 > BLOCK_W) ? OFFSET_BITS + 1 : BLOCK_W;

   logic                   s1_valid_ff;
   logic [7:0]             s1_byte_ff;
   logic                   s1_eos_ff;

   phase_type              phase_ff, phase_in;
   logic [2:0]             fill_ff, fill_in;
   logic [31:0]            rem_ff, rem_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   skip_ff, skip_in;
   logic [NUMBER_W-1:0]    num_ff, num_in;
   logic [7:0]             hdr_ff [8];
   logic [7:0]             hdr_in [8];

   logic [EW-1:0]          bs_raw;
   logic [EW-1:0]          bs_top;
   logic [EW-1:0]          bs_eff;
   logic [EW-1:0]          pos_inc;
   logic [OFFSET_BITS-1:0] next_off;
   logic                   pos_zero;
   logic                   wr_hdr;
   logic                   closed;
   logic [31:0]            hdr_size;
   logic [31:0]            hdr_kind;
   logic                   too_small;
   desc_type               desc;
   logic                   emit;

   // Effective block size, clamped to [8, 2^OFFSET_BITS], and the next offset.
   assign bs_raw  = EW'(cfg.block_size);
   assign bs_top  = EW'(1) << OFFSET_BITS;
   assign bs_eff  = (bs_raw < EW'(8)) ? EW'(8) : ((bs_raw > bs_top) ? bs_top : bs_raw);
   assign pos_inc = EW'(offset_ff) + EW'(1);
   assign next_off = (pos_inc >= bs_eff) ? '0 : pos_inc[OFFSET_BITS-1:0];
   assign pos_zero = (offset_ff == '0);

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      rem_in    = rem_ff;
      offset_in = offset_ff;
      skip_in   = skip_ff;
      num_in    = num_ff;
      hdr_in    = hdr_ff;
      emit      = 1'b0;
      desc      = '0;
      desc.number = num_ff;
      closed    = 1'b0;
      wr_hdr    = 1'b0;
      hdr_size  = '0;
      hdr_kind  = '0;
      too_small = 1'b0;
      if (s1_valid_ff) begin
         case (phase_ff)
            PH_COPY: begin
               emit              = 1'b1;
               desc.bytes[7:0]   = s1_byte_ff;
               desc.present      = 1'b1;
               rem_in            = rem_ff - 32'd1;
               if (rem_ff == 32'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               wr_hdr = 1'b1;
            end
            default: begin
               if ((fill_ff != 3'd0) || (pos_zero && !skip_ff)) begin
                  wr_hdr = 1'b1;
               end else if (pos_zero) begin
                  skip_in = 1'b0;
               end
            end
         endcase

         if (wr_hdr) begin
            hdr_in[fill_ff] = s1_byte_ff;
            fill_in         = fill_ff + 3'd1;
         end

         hdr_size  = {hdr_in[0], hdr_in[1], hdr_in[2], hdr_in[3]};
         hdr_kind  = {hdr_in[4], hdr_in[5], hdr_in[6], hdr_in[7]};
         too_small = (hdr_size < 32'd8);

         // Eighth header byte: judge the whole header.
         if (wr_hdr && (fill_ff == 3'd7)) begin
            if (phase_ff == PH_HEADER) begin
               if (too_small || !type_ok(hdr_kind)) begin
                  emit     = 1'b1;
                  desc.fin = 1'b1;
                  phase_in = PH_SCAN;
                  closed   = 1'b1;
               end else begin
                  emit       = 1'b1;
                  desc.burst = 1'b1;
                  desc.present = 1'b1;
                  desc.bytes = {hdr_in[7], hdr_in[6], hdr_in[5], hdr_in[4],
                                hdr_in[3], hdr_in[2], hdr_in[1], hdr_in[0]};
                  rem_in     = hdr_size - 32'd8;
                  phase_in   = (hdr_size == 32'd8) ? PH_HEADER : PH_COPY;
               end
            end else if (hdr_kind == TYPE_FTYP) begin
               num_in      = num_ff + NUMBER_W'(1);
               desc.number = num_in;
               if (too_small) begin
                  emit       = 1'b1;
                  desc.start = 1'b1;
                  desc.fin   = 1'b1;
                  closed     = 1'b1;
               end else begin
                  emit         = 1'b1;
                  desc.burst   = 1'b1;
                  desc.present = 1'b1;
                  desc.start   = 1'b1;
                  desc.bytes   = {hdr_in[7], hdr_in[6], hdr_in[5], hdr_in[4],
                                  hdr_in[3], hdr_in[2], hdr_in[1], hdr_in[0]};
                  rem_in       = hdr_size - 32'd8;
                  phase_in     = (hdr_size == 32'd8) ? PH_HEADER : PH_COPY;
               end
            end
         end

         if (closed && (next_off == '0)) begin
            skip_in = 1'b1;
         end
         offset_in = next_off;

         // End of the image closes an open movie and restarts the scan.
         if (s1_eos_ff) begin
            if (phase_in != PH_SCAN) begin
               desc.fin = 1'b1;
               emit     = 1'b1;
            end
            phase_in  = PH_SCAN;
            fill_in   = '0;
            rem_in    = '0;
            offset_in = '0;
            skip_in   = 1'b0;
         end
      end
      if (cfg.number_load) begin
         num_in = cfg.number_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= PH_SCAN;
         fill_ff     <= '0;
         rem_ff      <= '0;
         offset_ff   <= '0;
         skip_ff     <= 1'b0;
         num_ff      <= FIRST_NUMBER_RESET;
      end else begin
         s1_valid_ff <= in_load;
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         rem_ff      <= rem_in;
         offset_ff   <= offset_in;
         skip_ff     <= skip_in;
         num_ff      <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         s1_byte_ff <= in_byte;
         s1_eos_ff  <= in_eos;
      end
      hdr_ff <= hdr_in;
   end

   assign busy      = s1_valid_ff;
   assign push      = emit;
   assign push_desc = desc;

endmodule

// ===== design/masc_queue.sv =====
// Result queue and serialiser that expands header bursts into single results.
module masc_queue
   import masc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  desc_type                 push_desc,
   output logic [QUEUE_LEVEL_W-1:0] level,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output res_type                  rsp
);

   desc_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_W-1:0] count_ff, count_in;
   desc_type                 cur_ff;
   logic                     cur_valid_ff, cur_valid_in;
   logic [2:0]               idx_ff, idx_in;
   logic                     last_now;
   logic                     fire;
   logic                     free;
   logic                     pop;

   assign last_now = !cur_ff.burst || (idx_ff == 3'd7);
   assign fire     = cur_valid_ff & rsp_ready;
   assign free     = !cur_valid_ff || (fire && last_now);
   assign pop      = free && (count_ff != '0);

   always_comb begin
      wr_ptr_in    = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + QUEUE_LEVEL_W'(push) - QUEUE_LEVEL_W'(pop);
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (free) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
      if (pop) begin
         cur_ff <= mem[rd_ptr_ff];
      end
   end

   assign level     = count_ff;
   assign rsp_valid = cur_valid_ff;

   always_comb begin
      rsp.out_byte     = cur_ff.burst ? cur_ff.bytes[8*idx_ff +: 8] : cur_ff.bytes[7:0];
      rsp.byte_present = cur_ff.present;
      rsp.file_number  = cur_ff.number;
      rsp.file_start   = cur_ff.start && (idx_ff == 3'd0);
      rsp.file_end     = cur_ff.fin && last_now;
      rsp.run_last     = last_now;
   end

endmodule

// ===== design/mov_atom_stream_carver.sv =====
// Top level of the movie atom carver: configuration, parser and result queue.
//
//   Channel   Direction  Transfer contents
//   req_*     in         tdata[7:0] data_byte; tlast end_of_stream
//   rsp_*     out        tdata out_byte, file_number, file_start, file_end; tuser
//                        byte_present; tlast run_last
//   csr_*     in/out     APB-style access to block_size (0x0) and first_number (0x4)
//
// One input transfer can be taken in every cycle while req_tready is high. Each byte is
// held in the input register, where the parser updates its scan state and writes at
// most one entry into a four-entry result queue; the serialiser then sends one result
// per cycle while rsp_tready is high, so an accepted atom header takes eight results.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stall on the result side fills the queue, after which req_tready drops.
module mov_atom_stream_carver
   import masc_pkg::*;
#(
   parameter int OFFSET_BITS = 24
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [7:0] out_byte, [39:8] file_number,
                                     // [40] file_start, [41] file_end, [47:42] zero
   output logic        rsp_tuser,    // [0] byte_present
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type                  cfg;
   logic                     busy;
   logic                     push;
   desc_type                 push_desc;
   logic [QUEUE_LEVEL_W-1:0] q_level;
   logic [QUEUE_LEVEL_W:0]   committed;
   logic                     in_load;
   res_type                  rsp;

   masc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A byte in the input register may still write an entry into the queue, so it
   // counts against the free space before a new transfer is taken.
   assign committed  = (QUEUE_LEVEL_W+1)'(q_level) + (QUEUE_LEVEL_W+1)'(busy);
   assign req_tready = (committed < (QUEUE_LEVEL_W+1)'(QUEUE_DEPTH));
   assign in_load    = req_tvalid & req_tready;

   masc_parse #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_load   (in_load),
      .in_byte   (req_tdata),
      .in_eos    (req_tlast),
      .busy      (busy),
      .push      (push),
      .push_desc (push_desc)
   );

   masc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .level     (q_level),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.file_end, rsp.file_start, rsp.file_number, rsp.out_byte};
   assign rsp_tuser = rsp.byte_present;
   assign rsp_tlast = rsp.run_last;

   // The admission rule must keep the queue from ever overflowing.
   assert property (@(posedge clock) disable iff (reset)
      q_level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // A pure end marker always closes a movie.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tdata[41])
      else $error("end marker without file_end");

   // A pure end marker is always the last result of its input byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("end marker not last of run");

   // A movie that opens with data opens with an eight-byte header burst.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && rsp_tdata[40]) |-> !rsp_tlast)
      else $error("file start not at head of header burst");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the streaming QuickTime atom carver.
module tb_top;
   import masc_pkg::*;

   localparam int OFFSET_BITS   = 24;
   // A byte is held in the input register before the serialiser sees its result, and
   // the settle wait after the last result also covers a byte that produces nothing.
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 150;
   localparam int PRINT_CAP     = 30;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] data_byte
   logic        req_tlast   = 1'b0;    // end_of_stream
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;             // [7:0] out_byte, [39:8] file_number,
                                       // [40] file_start, [41] file_end
   logic        rsp_tuser;             // [0] byte_present
   logic        rsp_tlast;             // run_last
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mov_atom_stream_carver #(.OFFSET_BITS(OFFSET_BITS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut short if the carver stops making progress.
   initial begin
      #2_000_000;
      $display("mov_atom_stream_carver test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Shared bench state.
   // ---------------------------------------------------------------------
   logic idling  = 1'b1;   // random gaps on both sides while set
   logic holding = 1'b0;   // long receiver hold-off in progress
   int   rsp_gap = 0;
   int   bytes_sent  = 0;
   int   error_count = 0;
   event hold_go;

   logic [31:0] atom_kinds [7] = '{TYPE_FTYP, TYPE_MOOV, TYPE_MDAT, TYPE_FREE,
                                   TYPE_SKIP, TYPE_WIDE, TYPE_PNOT};

   // ---------------------------------------------------------------------
   // Carving predictor. It keeps its own copy of the parser state and of the
   // two registers, and turns every accepted byte into the results it must
   // cause, which are queued in carved_results in the order of arrival.
   // ---------------------------------------------------------------------
   res_type     carved_results [$];
   logic [24:0] cfg_block  = BLOCK_SIZE_RESET;
   logic [31:0] cfg_first  = FIRST_NUMBER_RESET;
   logic [7:0]  hdr_bytes [8];
   int          hdr_fill   = 0;
   phase_type   parse_phase = PH_SCAN;
   logic [31:0] atom_left  = '0;
   longint      blk_off    = 0;
   logic [31:0] cur_num    = FIRST_NUMBER_RESET;
   bit          skip_bnd   = 1'b0;
   int          step_emits = 0;

   function automatic longint block_span();
      longint top;
      top = longint'(1) << OFFSET_BITS;
      if (cfg_block < 25'd8) return 8;
      if (longint'(cfg_block) > top) return top;
      return longint'(cfg_block);
   endfunction

   function automatic logic [31:0] hdr_word(input int at);
      return {hdr_bytes[at], hdr_bytes[at+1], hdr_bytes[at+2], hdr_bytes[at+3]};
   endfunction

   function automatic bit known_atom(input logic [31:0] code);
      case (code)
         TYPE_FTYP, TYPE_MOOV, TYPE_MDAT, TYPE_FREE,
         TYPE_SKIP, TYPE_WIDE, TYPE_PNOT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void carve_emit(input logic [7:0] value, input logic present,
                                      input logic start, input logic fin);
      res_type r;
      r.out_byte     = present ? value : 8'h00;
      r.byte_present = present;
      r.file_number  = cur_num;
      r.file_start   = start;
      r.file_end     = fin;
      r.run_last     = 1'b0;
      carved_results.push_back(r);
      step_emits++;
   endfunction

   // An accepted header is replayed in full, then the body is copied.
   function automatic void carve_open_atom(input logic [31:0] size, input bit first);
      for (int i = 0; i < 8; i++)
         carve_emit(hdr_bytes[i], 1'b1, first && i == 0, 1'b0);
      atom_left   = size - 32'd8;
      parse_phase = (atom_left != 0) ? PH_COPY : PH_HEADER;
   endfunction

   function automatic void carve_restart();
      hdr_fill    = 0;
      parse_phase = PH_SCAN;
      atom_left   = '0;
      blk_off     = 0;
      skip_bnd    = 1'b0;
   endfunction

   function automatic void carve_byte(input logic [7:0] value, input logic eos);
      longint      span;
      longint      nxt;
      bit          closed;
      bit          open_at_end;
      logic [31:0] size_word;
      res_type     last;
      span       = block_span();
      nxt        = (blk_off + 1 >= span) ? 0 : blk_off + 1;
      closed     = 1'b0;
      step_emits = 0;
      case (parse_phase)
         PH_COPY: begin
            carve_emit(value, 1'b1, 1'b0, 1'b0);
            atom_left = atom_left - 32'd1;
            if (atom_left == 0) parse_phase = PH_HEADER;
         end
         PH_HEADER: begin
            hdr_bytes[hdr_fill % 8] = value;
            hdr_fill++;
            if (hdr_fill >= 8) begin
               hdr_fill  = 0;
               size_word = hdr_word(0);
               if (size_word < 32'd8 || !known_atom(hdr_word(4))) begin
                  // A broken header inside a movie closes it without replaying the bytes.
                  carve_emit(8'h00, 1'b0, 1'b0, 1'b1);
                  parse_phase = PH_SCAN;
                  closed      = 1'b1;
               end else begin
                  carve_open_atom(size_word, 1'b0);
               end
            end
         end
         default: begin
            parse_phase = PH_SCAN;
            if (hdr_fill > 0 || (blk_off == 0 && !skip_bnd)) begin
               hdr_bytes[hdr_fill % 8] = value;
               hdr_fill++;
            end else if (blk_off == 0) begin
               skip_bnd = 1'b0;
            end
            if (hdr_fill >= 8) begin
               hdr_fill = 0;
               if (hdr_word(4) == TYPE_FTYP) begin
                  size_word = hdr_word(0);
                  cur_num   = cur_num + 32'd1;
                  if (size_word < 32'd8) begin
                     // A start atom that is too small opens and closes the movie at once.
                     carve_emit(8'h00, 1'b0, 1'b1, 1'b1);
                     closed = 1'b1;
                  end else begin
                     carve_open_atom(size_word, 1'b1);
                  end
               end
            end
         end
      endcase

      // A close just before a boundary means that boundary is not a candidate.
      if (closed && nxt == 0) skip_bnd = 1'b1;
      blk_off = nxt;

      open_at_end = (parse_phase != PH_SCAN);
      if (eos && open_at_end && step_emits == 0) carve_emit(8'h00, 1'b0, 1'b0, 1'b1);
      if (step_emits > 0) begin
         last          = carved_results.pop_back();
         last.run_last = 1'b1;
         if (eos && open_at_end) last.file_end = 1'b1;
         carved_results.push_back(last);
      end
      if (eos) carve_restart();
   endfunction

   // ---------------------------------------------------------------------
   // Result checking. Every result transfer is compared with the oldest
   // prediction; outputs are sampled at the rising edge, before any update.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : result_check
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (carved_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, byte %02h file %0d",
                                      rsp_tdata[7:0], rsp_tdata[39:8]));
         end else begin
            want = carved_results.pop_front();
            check_field("out_byte",     rsp_tdata[7:0],  want.out_byte);
            check_field("byte_present", rsp_tuser,       want.byte_present);
            check_field("file_number",  rsp_tdata[39:8], want.file_number);
            check_field("file_start",   rsp_tdata[40],   want.file_start);
            check_field("file_end",     rsp_tdata[41],   want.file_end);
            check_field("run_last",     rsp_tlast,       want.run_last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver. Short random stalls while idling is set, and a long hold-off on
   // request so that the output queue fills and the carver has to refuse input
   // transfers.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holding) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : receiver_hold
      forever begin
         @(hold_go);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Sender and register access. Every task starts and ends on a rising edge.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input logic eos);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      carve_byte(value, eos);
      bytes_sent++;
   endtask

   // Wait until every predicted result has been seen and the carver is idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (carved_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_index == REG_BLOCK_SIZE) begin
         cfg_block = value[24:0];
      end else begin
         cfg_first = value;
         cur_num   = value;
      end
   endtask

   // Big-endian word; the last byte may carry the end-of-stream flag.
   task automatic send_word(input logic [31:0] w, input logic eos_last);
      for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8], eos_last && i == 0);
   endtask

   task automatic send_header(input logic [31:0] size, input logic [31:0] kind,
                              input logic eos_last);
      send_word(size, 1'b0);
      send_word(kind, eos_last);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic align_block();
      while (blk_off != 0) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic end_image();
      send_byte(8'($urandom), 1'b1);
   endtask

   // A movie with random content that ends in one of the ways a movie can end.
   task automatic send_random_movie();
      int lead;
      int size;
      align_block();
      lead = $urandom_range(0, 8);
      send_header(32'(8 + lead), TYPE_FTYP, 1'b0);
      send_noise(lead);
      repeat ($urandom_range(0, 3)) begin
         size = $urandom_range(8, 20);
         send_header(32'(size), atom_kinds[$urandom_range(0, 6)], 1'b0);
         send_noise(size - 8);
      end
      case ($urandom_range(0, 5))
         0: send_header(32'($urandom_range(0, 7)), atom_kinds[$urandom_range(0, 6)], 1'b0);
         1: send_header(32'($urandom_range(8, 40)), $urandom, 1'b0);
         2: begin
            send_header(32'hFFFF_FFFF - 32'($urandom_range(0, 3)), TYPE_MDAT, 1'b0);
            send_noise($urandom_range(0, 6));
            end_image();
         end
         3: begin
            send_noise($urandom_range(0, 6));
            end_image();
         end
         4: send_header(32'($urandom_range(8, 12)), atom_kinds[$urandom_range(0, 6)], 1'b1);
         default: end_image();
      endcase
   endtask

   // Raw image bytes with an occasional end of stream and a stray start code.
   task automatic send_noise_burst();
      repeat ($urandom_range(4, 16)) send_byte(8'($urandom), $urandom_range(0, 39) == 0);
      if ($urandom_range(0, 2) == 0) send_word(TYPE_FTYP, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Register values after reset: 512-byte blocks and numbering from zero.
   task automatic test_reset_defaults();
      send_header(32'd8, TYPE_FTYP, 1'b0);
      send_header(32'd10, TYPE_MOOV, 1'b0);
      send_noise(2);
      end_image();
   endtask

   // Block sizes below the minimum and above the offset range are clamped.
   task automatic test_block_extremes();
      logic [31:0] sizes [4] = '{32'd0, 32'd7, 32'h0100_0000, 32'h01FF_FFFF};
      foreach (sizes[i]) begin
         settle();
         csr_write(REG_BLOCK_SIZE, sizes[i]);
         send_header(32'hFFFF_FFFF, TYPE_FTYP, 1'b0);
         end_image();
      end
   endtask

   // A start atom with a size below eight, followed by the skipped boundary
   // right after it, and file numbers wrapping past the top.
   task automatic test_short_start_atom();
      settle();
      csr_write(REG_BLOCK_SIZE, 32'd8);
      csr_write(REG_FIRST_NUMBER, 32'hFFFF_FFFF);
      send_header(32'd7, TYPE_FTYP, 1'b0);
      send_header(32'd8, TYPE_FTYP, 1'b0);
      send_header(32'd0, TYPE_FTYP, 1'b0);
      end_image();
   endtask

   // Broken headers inside a movie: a size that is too small, then an unknown type.
   task automatic test_bad_headers();
      settle();
      csr_write(REG_BLOCK_SIZE, 32'd16);
      csr_write(REG_FIRST_NUMBER, 32'd100);
      send_header(32'd8, TYPE_FTYP, 1'b0);
      send_header(32'd3, TYPE_FREE, 1'b0);
      send_header(32'd16, TYPE_FTYP, 1'b0);
      align_block();
      send_header(32'd12, TYPE_FTYP, 1'b0);
      send_noise(4);
      send_header(32'd20, 32'h6162_6364, 1'b0);
      end_image();
   endtask

   // Shrinking the block size below the current offset makes the offset wrap;
   // the end of stream then lands on the last byte of an accepted header.
   task automatic test_block_shrink();
      settle();
      csr_write(REG_BLOCK_SIZE, 32'd64);
      send_noise(40);
      settle();
      csr_write(REG_BLOCK_SIZE, 32'd16);
      send_noise(1);
      send_header(32'd8, TYPE_FTYP, 1'b1);
   endtask

   task automatic test_random_movies();
      int first_count;
      first_count = bytes_sent;
      while (bytes_sent - first_count < 150) begin
         if ($urandom_range(0, 4) == 0) begin
            settle();
            csr_write(REG_BLOCK_SIZE, 32'($urandom_range(0, 40)));
            if ($urandom_range(0, 1) == 1) csr_write(REG_FIRST_NUMBER, $urandom);
         end
         if ($urandom_range(0, 3) == 0) send_noise_burst();
         else send_random_movie();
      end
   endtask

   // Header bursts while the receiver holds off: the queue fills and input stalls.
   task automatic test_backpressure();
      settle();
      csr_write(REG_BLOCK_SIZE, 32'd8);
      -> hold_go;
      send_header(32'd8, TYPE_FTYP, 1'b0);
      repeat (6) send_header(32'd8, atom_kinds[$urandom_range(1, 6)], 1'b0);
      end_image();
   endtask

   // The last stretch runs without gaps on either side.
   task automatic test_quiet_finish();
      settle();
      idling <= 1'b0;
      csr_write(REG_BLOCK_SIZE, 32'd12);
      repeat (2) send_random_movie();
      end_image();
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_block_extremes();
      test_short_start_atom();
      test_bad_headers();
      test_block_shrink();
      test_random_movies();
      test_backpressure();
      test_quiet_finish();
      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("mov_atom_stream_carver test passed");
      end else begin
         $display("mov_atom_stream_carver test failed");
      end
      $finish;
   end

endmodule
